// ===== design/pctok_pkg.sv =====
// types and constants shared by the tokenizer modules
package pctok_pkg;

   // token kind codes carried in token_kind
   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_IDENT   = 4'd2;
   localparam logic [3:0] KIND_NUMBER  = 4'd3;
   localparam logic [3:0] KIND_LPAR    = 4'd4;
   localparam logic [3:0] KIND_RPAR    = 4'd5;
   localparam logic [3:0] KIND_EQUAL   = 4'd6;
   localparam logic [3:0] KIND_QUERY   = 4'd7;
   localparam logic [3:0] KIND_DASH    = 4'd8;
   localparam logic [3:0] KIND_BAD     = 4'd9;

   // most results one source byte can cause
   localparam int MaxResults = 3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_KEYWORD = 3'd2,
      MODE_IDENT   = 3'd3,
      MODE_NUMBER  = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_char;
      logic               char_in_token;
      logic               token_done;
      logic [3:0]         token_kind;
      logic signed [15:0] paren_level;
      logic [15:0]        line_count;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic        dot_seen;
      logic [15:0] nesting_level;
      logic [15:0] lines_seen;
   } lex_state_type;

   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [MaxResults-1:0]     results;
   } step_type;

endpackage

// ===== design/pctok_step.sv =====
// combinational lexer step: one byte and the current state give results and next state
module pctok_step (
   input  pctok_pkg::lex_state_type state_cur,
   input  pctok_pkg::req_type       item,
   output pctok_pkg::step_type      step,
   output pctok_pkg::lex_state_type state_nxt
);

   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_SEMI   = 8'd59;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_QUERY  = 8'h3F;

   function automatic pctok_pkg::rsp_type make_rsp(
      input logic [7:0]               ch,
      input logic                     in_tok,
      input logic                     done,
      input logic [3:0]               kind,
      input pctok_pkg::lex_state_type s
   );
      pctok_pkg::rsp_type r;
      r.out_char      = ch;
      r.char_in_token = in_tok;
      r.token_done    = done;
      r.token_kind    = kind;
      r.paren_level   = $signed(s.nesting_level);
      r.line_count    = s.lines_seen;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   logic [7:0] c;
   logic       is_lower;
   logic       is_upper;
   logic       is_digit;

   assign c        = item.in_char;
   assign is_lower = (c >= 8'h61) && (c <= 8'h7A);
   assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
   assign is_digit = (c >= 8'h30) && (c <= 8'h39);

   pctok_pkg::lex_state_type                        st;
   pctok_pkg::rsp_type [pctok_pkg::MaxResults-1:0]  res;
   logic [1:0]                                      n;
   logic                                            end_tok;
   logic [3:0]                                      end_kind;
   logic                                            lex_again;

   always_comb begin
      st        = state_cur;
      res       = '0;
      n         = 2'd0;
      end_tok   = 1'b0;
      end_kind  = pctok_pkg::KIND_EOF;
      lex_again = 1'b0;

      case (state_cur.mode)
         pctok_pkg::MODE_COMMENT: begin
            if (c == CH_LF) begin
               st.lines_seen = st.lines_seen + 16'd1;
               st.mode       = pctok_pkg::MODE_IDLE;
            end
         end
         pctok_pkg::MODE_KEYWORD: begin
            if (is_lower || c == CH_DASH) begin
               res[0] = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
               n      = 2'd1;
            end else begin
               end_tok  = 1'b1;
               end_kind = pctok_pkg::KIND_KEYWORD;
            end
         end
         pctok_pkg::MODE_IDENT: begin
            if (is_lower || is_upper || is_digit || c == CH_DASH ||
                c == CH_USCORE || c == CH_DOT) begin
               res[0] = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
               n      = 2'd1;
            end else begin
               end_tok  = 1'b1;
               end_kind = pctok_pkg::KIND_IDENT;
            end
         end
         pctok_pkg::MODE_NUMBER: begin
            if (is_digit) begin
               res[0] = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
               n      = 2'd1;
            end else if (c == CH_DOT && !state_cur.dot_seen) begin
               st.dot_seen = 1'b1;
               res[0]      = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
               n           = 2'd1;
            end else begin
               end_tok  = 1'b1;
               end_kind = pctok_pkg::KIND_NUMBER;
            end
         end
         default: begin
            st.mode   = pctok_pkg::MODE_IDLE;
            lex_again = 1'b1;
         end
      endcase

      // close the open token, then lex the byte again from idle
      if (end_tok) begin
         st.mode     = pctok_pkg::MODE_IDLE;
         st.dot_seen = 1'b0;
         res[0]      = make_rsp(8'd0, 1'b0, 1'b1, end_kind, st);
         n           = 2'd1;
         lex_again   = 1'b1;
      end

      if (lex_again) begin
         if (c == CH_SPACE || c == CH_TAB) begin
            st.mode = st.mode;
         end else if (c == CH_LF || c == CH_CR) begin
            st.lines_seen = st.lines_seen + 16'd1;
         end else if (c == CH_SEMI) begin
            st.mode = pctok_pkg::MODE_COMMENT;
         end else if (c == CH_COLON) begin
            st.mode = pctok_pkg::MODE_KEYWORD;
            res[n]  = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
            n       = n + 2'd1;
         end else if (is_lower || is_upper) begin
            st.mode = pctok_pkg::MODE_IDENT;
            res[n]  = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
            n       = n + 2'd1;
         end else if (is_digit) begin
            st.mode     = pctok_pkg::MODE_NUMBER;
            st.dot_seen = 1'b0;
            res[n]      = make_rsp(c, 1'b1, 1'b0, pctok_pkg::KIND_EOF, st);
            n           = n + 2'd1;
         end else if (c == CH_LPAR) begin
            st.nesting_level = st.nesting_level + 16'd1;
            res[n]           = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_LPAR, st);
            n                = n + 2'd1;
         end else if (c == CH_RPAR) begin
            st.nesting_level = st.nesting_level - 16'd1;
            res[n]           = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_RPAR, st);
            n                = n + 2'd1;
         end else if (c == CH_EQUAL) begin
            res[n] = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_EQUAL, st);
            n      = n + 2'd1;
         end else if (c == CH_QUERY) begin
            res[n] = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_QUERY, st);
            n      = n + 2'd1;
         end else if (c == CH_DASH) begin
            res[n] = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_DASH, st);
            n      = n + 2'd1;
         end else begin
            res[n] = make_rsp(c, 1'b1, 1'b1, pctok_pkg::KIND_BAD, st);
            n      = n + 2'd1;
         end
      end

      // end of buffer: flag a cut-off token, then back to reset state
      if (item.in_last) begin
         if (st.mode == pctok_pkg::MODE_KEYWORD || st.mode == pctok_pkg::MODE_IDENT ||
             st.mode == pctok_pkg::MODE_NUMBER) begin
            res[n] = make_rsp(8'd0, 1'b0, 1'b1, pctok_pkg::KIND_EOF, st);
            n      = n + 2'd1;
         end
         st.mode          = pctok_pkg::MODE_IDLE;
         st.dot_seen      = 1'b0;
         st.nesting_level = 16'd0;
         st.lines_seen    = 16'd0;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].last_of_run = 1'b1;
      end
   end

   assign step.count   = n;
   assign step.results = res;
   assign state_nxt    = st;

endmodule

// ===== design/pctok_rsp_reg.sv =====
// output register slice for result transactions
module pctok_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pctok_pkg::rsp_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output pctok_pkg::rsp_type out_item
);

   logic               valid_ff;
   logic               valid_in;
   pctok_pkg::rsp_type item_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== design/pddl_char_tokenizer.sv =====
// top level of the streaming pddl character tokenizer
// One source byte per req transaction; each byte gives zero to three rsp
// transactions (token characters, token-end events and an end-of-file event
// for a token cut off by the byte marked in_last). Bytes are held in an input
// register while the step logic works out all their results at once from the
// lexer state; results then leave through a one-entry output register, one per
// cycle while rsp_ready is high. Throughput is one byte per cycle for bytes that
// give zero or one result when the output does not stall; a byte with more
// results keeps the input register until its last result has gone out. A byte's
// results come from the input register and then pass the output register.
// Whitespace, newlines and comment bytes give no result but the end of a token
// they close. Lexer state (mode, nesting level, line count) advances only when
// every result of the held byte has moved into the output register, and returns
// to its reset value after the byte marked in_last. No clearing pass is needed after reset.
module pddl_char_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pctok_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pctok_pkg::rsp_type rsp_item
);

   // input register holding the byte being lexed
   logic                     held_valid_ff;
   logic                     held_valid_in;
   pctok_pkg::req_type       held_item_ff;

   // index of the next result of the held byte to hand on
   logic [1:0]               sel_ff;
   logic [1:0]               sel_in;

   // lexer state
   pctok_pkg::lex_state_type state_ff;
   pctok_pkg::lex_state_type state_in;

   pctok_pkg::step_type      step;
   pctok_pkg::lex_state_type state_nxt;

   logic                     emit_valid;
   logic                     emit_ready;
   logic                     emit_fire;
   logic                     item_done;
   logic                     req_fire;

   pctok_step u_step (
      .state_cur (state_ff),
      .item      (held_item_ff),
      .step      (step),
      .state_nxt (state_nxt)
   );

   // a held byte with results offers them one at a time
   assign emit_valid = held_valid_ff && (step.count != 2'd0);
   assign emit_fire  = emit_valid && emit_ready;

   // byte retires when it had no result or its final result goes out
   assign item_done = held_valid_ff &&
                      ((step.count == 2'd0) ||
                       (emit_fire && (sel_ff == step.count - 2'd1)));

   assign req_ready = !held_valid_ff || item_done;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      held_valid_in = held_valid_ff;
      sel_in        = sel_ff;
      state_in      = state_ff;
      if (item_done) begin
         held_valid_in = 1'b0;
         sel_in        = 2'd0;
         state_in      = state_nxt;
      end else if (emit_fire) begin
         sel_in = sel_ff + 2'd1;
      end
      if (req_fire) begin
         held_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff          <= 1'b0;
         sel_ff                 <= 2'd0;
         state_ff.mode          <= pctok_pkg::MODE_IDLE;
         state_ff.dot_seen      <= 1'b0;
         state_ff.nesting_level <= 16'd0;
         state_ff.lines_seen    <= 16'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         sel_ff        <= sel_in;
         state_ff      <= state_in;
      end
   end

   // payload register: no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         held_item_ff <= req_item;
      end
   end

   pctok_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_valid),
      .in_ready  (emit_ready),
      .in_item   (step.results[sel_ff]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

endmodule
